// ----- design/assert_macros.svh -----
// Assertion shorthands used by the block's datapath.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define RFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/rfa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared constants, operation codes and controller/datapath interface types
// for the rational fraction ALU.
// ----------------------------------------------------------------------------
package rfa_pkg;

    // Operand bits that are used; upper port bits are ignored.
    localparam int IN_W     = 32;
    localparam int PROD_W   = 2 * IN_W;
    localparam int WORD_W   = 64;
    localparam int DEN_W    = 63;
    localparam int SHIFT_W  = 6;
    localparam int DIV_CNT_W = 6;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Which cross product the shared multiplier forms.
    localparam logic [1:0] MUL_P0 = 2'd0;
    localparam logic [1:0] MUL_P1 = 2'd1;
    localparam logic [1:0] MUL_P2 = 2'd2;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_NORM,
        ST_GCD,
        ST_DIVN,
        ST_DSWAP,
        ST_DIVD,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       sum_en;
        logic       gcd_init;
        logic       gcd_step;
        logic       div_init;
        logic       div_den;
        logic       div_step;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic dz;
        logic ovf;
        logic num_zero;
        logic gcd_done;
    } sts_t;

    // Two's complement pattern of a sign and magnitude pair.
    function automatic logic [WORD_W-1:0] to_tc(input logic [WORD_W-1:0] mag,
                                                input logic neg);
        return neg ? (~mag + 1'b1) : mag;
    endfunction

endpackage

// ----- design/rfa_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_datapath
// Operand registers, shared multiplier, cross-product sum, binary gcd engine,
// restoring divider and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rfa_datapath
    import rfa_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    input  logic [1:0]               in_req_type,
    input  logic signed [31:0]       in_a_num,
    input  logic signed [31:0]       in_a_den,
    input  logic signed [31:0]       in_b_num,
    input  logic signed [31:0]       in_b_den,
    output logic signed [WORD_W-1:0] res_num,
    output logic [DEN_W-1:0]         res_den,
    output logic                     res_div_zero,
    output logic                     res_overflow
);

    logic [1:0]        op_reg;
    logic [IN_W-1:0]   an_reg, ad_reg, bn_reg, bd_reg;
    logic              an_neg_reg, ad_neg_reg, bn_neg_reg, bd_neg_reg;
    logic              dz_reg;
    logic [WORD_W-1:0] pm_reg [3];
    logic              ps_reg [3];
    logic [WORD_W-1:0] num_reg;
    logic              ovf_reg;
    logic [WORD_W-1:0] x_reg, y_reg, nm_reg, dm_reg, g_reg;
    logic [SHIFT_W-1:0] k_reg;
    logic              rneg_reg;
    logic [WORD_W-1:0] rem_reg, q_reg, nq_reg;
    logic signed [WORD_W-1:0] res_num_reg;
    logic [DEN_W-1:0]  res_den_reg;
    logic              res_dz_reg, res_ovf_reg;

    logic [IN_W-1:0]   an_v, ad_v, bn_v, bd_v;
    logic [IN_W-1:0]   ma, mb;
    logic              sa, sb;
    logic [PROD_W-1:0] prod;
    logic [WORD_W-1:0] t0, t1, sum;
    logic              sum_ovf;
    logic [WORD_W:0]   rem_sh, rem_diff;
    logic              rem_ge;

    assign an_v = in_a_num[IN_W-1:0];
    assign ad_v = in_a_den[IN_W-1:0];
    assign bn_v = in_b_num[IN_W-1:0];
    assign bd_v = in_b_den[IN_W-1:0];

    // Operand selection for the shared multiplier.
    always_comb begin
        ma = ad_reg;
        sa = ad_neg_reg;
        mb = bd_reg;
        sb = bd_neg_reg;
        case (cmd.mul_sel)
            MUL_P0: begin
                ma = an_reg;
                sa = an_neg_reg;
                mb = (op_reg == OP_MUL) ? bn_reg : bd_reg;
                sb = (op_reg == OP_MUL) ? bn_neg_reg : bd_neg_reg;
            end
            MUL_P1: begin
                mb = bn_reg;
                sb = bn_neg_reg;
            end
            default: begin
                mb = (op_reg == OP_DIV) ? bn_reg : bd_reg;
                sb = (op_reg == OP_DIV) ? bn_neg_reg : bd_neg_reg;
            end
        endcase
    end

    assign prod = PROD_W'(ma) * PROD_W'(mb);

    // Cross-product sum with signed overflow detection.
    assign t0 = to_tc(pm_reg[0], ps_reg[0]);
    assign t1 = to_tc(pm_reg[1], ps_reg[1] ^ (op_reg == OP_SUB));
    assign sum = t0 + t1;
    assign sum_ovf = (t0[WORD_W-1] == t1[WORD_W-1]) && (sum[WORD_W-1] != t0[WORD_W-1]);

    // Restoring division step.
    assign rem_sh   = {rem_reg, q_reg[WORD_W-1]};
    assign rem_diff = rem_sh - {1'b0, g_reg};
    assign rem_ge   = !rem_diff[WORD_W];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= in_req_type;
            an_neg_reg <= an_v[IN_W-1];
            ad_neg_reg <= ad_v[IN_W-1];
            bn_neg_reg <= bn_v[IN_W-1];
            bd_neg_reg <= bd_v[IN_W-1];
            an_reg     <= an_v[IN_W-1] ? (~an_v + 1'b1) : an_v;
            ad_reg     <= ad_v[IN_W-1] ? (~ad_v + 1'b1) : ad_v;
            bn_reg     <= bn_v[IN_W-1] ? (~bn_v + 1'b1) : bn_v;
            bd_reg     <= bd_v[IN_W-1] ? (~bd_v + 1'b1) : bd_v;
            dz_reg     <= (ad_v == '0) || (bd_v == '0) ||
                          ((in_req_type == OP_DIV) && (bn_v == '0));
        end

        if (cmd.mul_en) begin
            pm_reg[cmd.mul_sel] <= WORD_W'(prod);
            ps_reg[cmd.mul_sel] <= sa ^ sb;
        end

        if (cmd.sum_en) begin
            if ((op_reg == OP_ADD) || (op_reg == OP_SUB)) begin
                num_reg <= sum;
                ovf_reg <= sum_ovf;
            end else begin
                num_reg <= t0;
                ovf_reg <= 1'b0;
            end
        end

        if (cmd.gcd_init) begin
            x_reg    <= num_reg[WORD_W-1] ? (~num_reg + 1'b1) : num_reg;
            nm_reg   <= num_reg[WORD_W-1] ? (~num_reg + 1'b1) : num_reg;
            y_reg    <= pm_reg[2];
            dm_reg   <= pm_reg[2];
            k_reg    <= '0;
            rneg_reg <= num_reg[WORD_W-1] ^ ps_reg[2];
        end else if (cmd.gcd_step && !sts.gcd_done) begin
            if (!x_reg[0] && !y_reg[0]) begin
                x_reg <= x_reg >> 1;
                y_reg <= y_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end else if (!x_reg[0]) begin
                x_reg <= x_reg >> 1;
            end else if (!y_reg[0]) begin
                y_reg <= y_reg >> 1;
            end else if (x_reg >= y_reg) begin
                x_reg <= x_reg - y_reg;
            end else begin
                y_reg <= y_reg - x_reg;
            end
        end

        if (cmd.div_init) begin
            rem_reg <= '0;
            if (cmd.div_den) begin
                nq_reg <= q_reg;
                q_reg  <= dm_reg;
            end else begin
                g_reg <= (x_reg | y_reg) << k_reg;
                q_reg <= nm_reg;
            end
        end else if (cmd.div_step) begin
            rem_reg <= rem_ge ? rem_diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
            q_reg   <= {q_reg[WORD_W-2:0], rem_ge};
        end

        if (cmd.out_load) begin
            res_num_reg <= '0;
            res_den_reg <= '0;
            res_dz_reg  <= 1'b0;
            res_ovf_reg <= 1'b0;
            if (dz_reg) begin
                res_dz_reg <= 1'b1;
            end else if (ovf_reg) begin
                res_ovf_reg <= 1'b1;
            end else if (num_reg == '0) begin
                res_den_reg <= DEN_W'(1);
            end else begin
                res_num_reg <= to_tc(nq_reg, rneg_reg);
                res_den_reg <= q_reg[DEN_W-1:0];
            end
        end
    end

    assign sts.dz       = dz_reg;
    assign sts.ovf      = ovf_reg;
    assign sts.num_zero = (num_reg == '0);
    assign sts.gcd_done = (x_reg == '0) || (y_reg == '0);

    assign res_num      = res_num_reg;
    assign res_den      = res_den_reg;
    assign res_div_zero = res_dz_reg;
    assign res_overflow = res_ovf_reg;

    `RFA_ASSERT_NOW(a_div_by_nonzero, cmd.div_step, g_reg != '0, "divider runs with zero gcd")
    `RFA_ASSERT_NEXT(a_flags_exclusive, cmd.out_load, !(res_dz_reg && res_ovf_reg), "both flags set")
    `RFA_ASSERT_NEXT(a_den_positive, cmd.out_load && !dz_reg && !ovf_reg, res_den_reg != '0,
        "valid result with zero denominator")

endmodule

// ----- design/rfa_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_controller
// Sequencer for one item: multiply, sum, gcd, two divisions, result hand-off.
// ----------------------------------------------------------------------------
module rfa_controller
    import rfa_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 slot_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // The result register may be refilled once its item has been taken.
    assign slot_free = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.mul_sel  = cnt_reg[1:0];
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (sts.dz) begin
                    if (slot_free) begin
                        cmd.out_load = 1'b1;
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    cmd.mul_en = 1'b1;
                    if (cnt_reg[1:0] == MUL_P2) begin
                        cnt_next   = '0;
                        state_next = ST_SUM;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_SUM: begin
                cmd.sum_en = 1'b1;
                state_next = ST_NORM;
            end
            ST_NORM: begin
                if (sts.ovf || sts.num_zero) begin
                    if (slot_free) begin
                        cmd.out_load = 1'b1;
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    cmd.gcd_init = 1'b1;
                    state_next   = ST_GCD;
                end
            end
            ST_GCD: begin
                if (sts.gcd_done) begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_DIVN;
                end else begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_DIVN: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_DSWAP;
                end
            end
            ST_DSWAP: begin
                cmd.div_init = 1'b1;
                cmd.div_den  = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIVD;
            end
            ST_DIVD: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (slot_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/rational_fraction_alu_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_fraction_alu_unit
// Exact add, subtract, multiply or divide of two signed fractions, with the
// result reduced to lowest terms by a binary gcd.
// ----------------------------------------------------------------------------
// The unit works on one item at a time. An item with a zero denominator (or a
// zero divisor in a divide) goes from the multiply state straight to the result
// register, once that register is free; an overflowing add/subtract or a zero
// numerator leaves from the normalise state after the multiply and sum states. A
// full reduction runs the multiply state for the three cross products, the sum
// and normalise states, the binary gcd loop (one shift or subtract per cycle)
// and the state that sees it finish, then two restoring divisions of the
// numerator and denominator by the gcd with a swap state and a final state.
// The gcd loop and the one-bit-per-cycle divider dominate an item's time. The
// result sits in an output register and is held on the m_ ports until it is
// taken. The next item is accepted the cycle after the result is registered,
// even while that result still waits; its own result then waits until the
// older one is taken. Only the low 32 operand bits are used, each field as a
// two's complement value. res_den is zero only when div_zero or overflow is
// reported, in which case res_num is zero too.
// ----------------------------------------------------------------------------
module rational_fraction_alu_unit
    import rfa_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_req_type,
    input  logic signed [31:0]       s_a_num,
    input  logic signed [31:0]       s_a_den,
    input  logic signed [31:0]       s_b_num,
    input  logic signed [31:0]       s_b_den,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [WORD_W-1:0] m_res_num,
    output logic [DEN_W-1:0]         m_res_den,
    output logic                     m_div_zero,
    output logic                     m_overflow
);

    cmd_t cmd;
    sts_t sts;

    // The controller sequences each item and owns the handshakes.
    rfa_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath holds operands, the arithmetic units and the result register.
    rfa_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .in_req_type  (s_req_type),
        .in_a_num     (s_a_num),
        .in_a_den     (s_a_den),
        .in_b_num     (s_b_num),
        .in_b_den     (s_b_den),
        .res_num      (m_res_num),
        .res_den      (m_res_den),
        .res_div_zero (m_div_zero),
        .res_overflow (m_overflow)
    );

endmodule

// ----- tb/rational_fraction_alu_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_fraction_alu_unit_test
// Drives fraction add, subtract, multiply and divide items into the unit, with
// random gaps and stalls on both channels, and compares every result against
// a fraction predictor that reduces with a Euclidean gcd.
// ----------------------------------------------------------------------------
module rational_fraction_alu_unit_test
    import rfa_pkg::*;
();

    // One expected result as it should appear on the m_ ports.
    typedef struct {
        logic [63:0] num;
        logic [62:0] den;
        logic        dz;
        logic        ovf;
    } fraction_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_req_type = OP_ADD;
    logic signed [31:0] s_a_num = '0;
    logic signed [31:0] s_a_den = '0;
    logic signed [31:0] s_b_num = '0;
    logic signed [31:0] s_b_den = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [63:0] m_res_num;
    logic [62:0] m_res_den;
    logic m_div_zero;
    logic m_overflow;

    fraction_result_t pending_results[$];
    int error_count = 0;
    // Set while the sink must hold off for the long back-pressure stretch.
    bit hold_sink = 1'b0;

    rational_fraction_alu_unit uut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Signed 32-bit operand split into a magnitude and a sign.
    function automatic logic [63:0] mag_of(input logic [31:0] v);
        return v[31] ? 64'(-$signed({32'hFFFF_FFFF, v})) : {32'd0, v};
    endfunction

    function automatic logic [63:0] signed_product(input logic [31:0] x, input logic [31:0] y);
        logic [63:0] p;
        p = mag_of(x) * mag_of(y);
        return (x[31] != y[31]) ? -p : p;
    endfunction

    function automatic logic [63:0] euclid_gcd(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] r;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    // Computes the reduced fraction the unit must return for one item.
    function automatic fraction_result_t reduce_fraction(input logic [1:0] op,
            input logic [31:0] an, input logic [31:0] ad,
            input logic [31:0] bn, input logic [31:0] bd);
        fraction_result_t r;
        logic [63:0] p1, p2, num, den, nm, dm, g;
        logic ovf;
        r = '{num: '0, den: '0, dz: 1'b0, ovf: 1'b0};
        ovf = 1'b0;
        if (ad == 0 || bd == 0 || (op == OP_DIV && bn == 0)) begin
            r.dz = 1'b1;
            return r;
        end
        case (op)
            OP_ADD, OP_SUB: begin
                p1 = signed_product(an, bd);
                p2 = signed_product(ad, bn);
                if (op == OP_SUB) p2 = -p2;
                num = p1 + p2;
                ovf = (p1[63] == p2[63]) && (num[63] != p1[63]);
                den = signed_product(ad, bd);
            end
            OP_MUL: begin
                num = signed_product(an, bn);
                den = signed_product(ad, bd);
            end
            default: begin
                num = signed_product(an, bd);
                den = signed_product(ad, bn);
            end
        endcase
        if (ovf) begin
            r.ovf = 1'b1;
            return r;
        end
        nm = num[63] ? -num : num;
        dm = den[63] ? -den : den;
        if (nm == 0) begin
            r.den = 63'd1;
        end else begin
            g = euclid_gcd(nm, dm);
            nm = nm / g;
            dm = dm / g;
            r.num = (num[63] != den[63]) ? -nm : nm;
            r.den = dm[62:0];
        end
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 2);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
            input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Offers one item and holds it until the unit takes it. Valid stays high
    // into the next item when there is no gap, and the caller drops it at the end.
    task automatic send_item(input logic [1:0] op, input logic [31:0] an,
            input logic [31:0] ad, input logic [31:0] bn, input logic [31:0] bd,
            input bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : gap_length();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= op;
        s_a_num <= an;
        s_a_den <= ad;
        s_b_num <= bn;
        s_b_den <= bd;
        pending_results.push_back(reduce_fraction(op, an, ad, bn, bd));
        do @(posedge aclk); while (!s_ready);
    endtask

    // Operand value biased toward the edges and small numbers.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return 32'($signed($urandom_range(0, 20)) - 10);
            3: return 32'($urandom_range(0, 4095)) << $urandom_range(0, 20);
            default: return $urandom;
        endcase
    endfunction

    // The sink side: random ready with a long hold-off on request.
    initial begin
        int wait_cycles;
        @(posedge aresetn);
        forever begin
            if (hold_sink) begin
                m_ready <= 1'b0;
                wait_cycles = 0;
                while (wait_cycles < 2000) begin
                    @(posedge aclk);
                    wait_cycles++;
                end
                hold_sink = 1'b0;
            end
            m_ready <= ($urandom_range(0, 3) != 0);
            @(posedge aclk);
        end
    end

    // Checks each accepted result against the oldest expectation.
    always @(posedge aclk) begin
        fraction_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item", m_res_num, 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (m_res_num !== want.num) report_mismatch("res_num", m_res_num, want.num);
                if (m_res_den !== want.den) begin
                    report_mismatch("res_den", 64'(m_res_den), 64'(want.den));
                end
                if (m_div_zero !== want.dz) begin
                    report_mismatch("div_zero", 64'(m_div_zero), 64'(want.dz));
                end
                if (m_overflow !== want.ovf) begin
                    report_mismatch("overflow", 64'(m_overflow), 64'(want.ovf));
                end
            end
        end
    end

    // Extremes of every field, each operation, and each special case.
    task automatic test_directed();
        send_item(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_item(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);   // zero numerator
        send_item(OP_MUL, -32'sd4, 32'd6, 32'd3, -32'sd8);
        send_item(OP_DIV, 32'd3, 32'd4, -32'sd9, 32'd8);
        send_item(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1);   // zero denominator
        send_item(OP_MUL, 32'd1, 32'd1, 32'd1, 32'd0);
        send_item(OP_DIV, 32'd5, 32'd7, 32'd0, 32'd3);   // zero divisor
        send_item(OP_DIV, 32'd0, 32'd0, 32'd0, 32'd0);
        // Extreme cross-product sums and differences (the first overflows), then extreme products and quotients.
        send_item(OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(OP_SUB, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(OP_SUB, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(OP_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(OP_DIV, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(OP_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFD, 32'h7FFF_FFFC);
        send_item(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_SUB, 32'd0, 32'h8000_0000, 32'd0, 32'd1);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_item(2'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                      pick_operand(), pick_operand());
        end
    endtask

    // The sink holds off while items keep coming, so the input stalls.
    task automatic test_back_pressure();
        hold_sink = 1'b1;
        for (int i = 0; i < 6; i++) begin
            send_item(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom, 1'b1);
        end
    endtask

    initial begin
        int drain;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_back_pressure();
        test_random(780);
        s_valid <= 1'b0;
        wait (pending_results.size() == 0);
        drain = 0;
        while (drain < 400) begin
            @(posedge aclk);
            drain++;
        end
        if (error_count == 0) begin
            $display("rational_fraction_alu_unit_test OK");
        end else begin
            $display("rational_fraction_alu_unit_test NOT OK");
        end
        $finish;
    end

    // About 800 items with their processing, the random gaps and the long sink
    // hold-off need under 5 ms, so this limit is generous.
    initial begin
        #40ms;
        $display("rational_fraction_alu_unit_test NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/rfa_pkg.sv
design/rfa_datapath.sv
design/rfa_controller.sv
design/rational_fraction_alu_unit.sv
tb/rational_fraction_alu_unit_test.sv
